// ===== hdl/rahmt_pkg.sv =====
package rahmt_pkg;

  localparam int unsigned ElementsDef = 1024;

  localparam logic signed [63:0] BIG = 64'sd1000000000000000000;

  localparam logic [10:0] ACTIVE_LENGTH_RST = 11'd1024;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_LENGTH = 3'd0;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_MAX   = 3'd1;
  localparam logic [2:0] FUNC_SUM   = 3'd2;
  localparam logic [2:0] FUNC_HMAX  = 3'd3;
  localparam logic [2:0] FUNC_HSUM  = 3'd4;
  localparam logic [2:0] FUNC_LOAD  = 3'd5;
  localparam logic [2:0] FUNC_BUILD = 3'd6;

endpackage

// ===== hdl/range_add_historic_max_tree.sv =====
// Range add with historic maximum over ELEMENTS values, kept as a lazy segment tree whose
// node records live in one node memory of 2*L-1 entries (L = ELEMENTS rounded up to a power
// of two) with one registered read port and one write port. A sequencer walks the tree with
// an explicit frame stack; every node access goes through the memory port. A query or add
// touches roughly 4*log2(L) nodes, a historic-gap repair can visit more, a leaf load writes
// one leaf and a rebuild rewrites every node. After reset the block runs the rebuild over
// all-zero leaves and holds s_axis_tready low until that pass is done; register writes are
// taken at any time. Results of the max and sum queries leave on the master side through
// an output register, so the next item is taken while a result still waits.
module range_add_historic_max_tree
  import rahmt_pkg::*;
#(
  parameter int unsigned ELEMENTS = ElementsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // slave side
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [95:0]        s_axis_tdata,   // func[2:0], range_start[13:3],
                                             // range_end[24:14], value[88:25]
  // master side
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // answer[63:0]
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned LOG_L  = $clog2(ELEMENTS);
  localparam int unsigned LEAVES = 1 << LOG_L;
  localparam int unsigned NODES  = 2 * LEAVES - 1;
  localparam int unsigned NODE_W = LOG_L + 1;
  localparam int unsigned POS_W  = LOG_L + 1;
  localparam int unsigned CNT_W  = LOG_L + 1;
  localparam int unsigned LEAF_W = LOG_L;
  localparam int unsigned DEP_W  = $clog2(LOG_L + 1);
  localparam int unsigned STK_D  = LOG_L + 1;
  localparam int unsigned SP_W   = $clog2(STK_D + 1);
  localparam int unsigned SPI_W  = $clog2(STK_D);

  localparam logic [1:0] K_AR = 2'd0;  // range add
  localparam logic [1:0] K_RG = 2'd1;  // raise gap minimum to zero
  localparam logic [1:0] K_QR = 2'd2;  // query

  localparam logic [1:0] P_ENTER = 2'd0;
  localparam logic [1:0] P_RIGHT = 2'd1;
  localparam logic [1:0] P_PULL  = 2'd2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_FRAME  = 5'd2;
  localparam logic [4:0] S_AR_RD  = 5'd3;
  localparam logic [4:0] S_AR_WR  = 5'd4;
  localparam logic [4:0] S_RG_RD  = 5'd5;
  localparam logic [4:0] S_RG_MUL = 5'd6;
  localparam logic [4:0] S_RG_WR  = 5'd7;
  localparam logic [4:0] S_QR_RD  = 5'd8;
  localparam logic [4:0] S_PD1    = 5'd9;
  localparam logic [4:0] S_PD2    = 5'd10;
  localparam logic [4:0] S_PD3    = 5'd11;
  localparam logic [4:0] S_PD4    = 5'd12;
  localparam logic [4:0] S_PD5    = 5'd13;
  localparam logic [4:0] S_PU_A   = 5'd14;
  localparam logic [4:0] S_PU_B   = 5'd15;
  localparam logic [4:0] S_RB_LRD = 5'd16;
  localparam logic [4:0] S_RB_LWR = 5'd17;
  localparam logic [4:0] S_RB_IRD = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  typedef struct packed {
    logic signed [63:0] sum, mx, pa, pp, gmin, gsec;
    logic [CNT_W-1:0]   cnt;
    logic signed [63:0] gsum, tvam, hm;
  } rec_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] k;
    logic [POS_W-1:0]  l;
    logic [DEP_W-1:0]  d;
    logic [1:0]        ph;
  } frame_t;

  function automatic logic signed [63:0] smax(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [63:0] smin(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic rec_t apply_add(input rec_t n, input logic signed [63:0] a,
                                     input logic signed [63:0] pk,
                                     input logic [DEP_W-1:0] sh);
    rec_t o;
    logic signed [63:0] as;
    o      = n;
    as     = a <<< sh;
    o.sum  = n.sum + as;
    o.mx   = n.mx + a;
    o.hm   = smax(n.hm, n.tvam + pk);
    o.tvam = n.tvam + a;
    o.gmin = n.gmin - a;
    o.gsec = n.gsec - a;
    o.gsum = n.gsum - as;
    o.pp   = smax(n.pp, n.pa + pk);
    o.pa   = n.pa + a;
    return o;
  endfunction

  function automatic rec_t pull_up(input rec_t lr, input rec_t rr);
    rec_t o;
    o      = lr;
    o.sum  = lr.sum + rr.sum;
    o.mx   = smax(lr.mx, rr.mx);
    o.gsum = lr.gsum + rr.gsum;
    o.hm   = smax(lr.hm, rr.hm);
    o.pa   = '0;
    o.pp   = '0;
    if (lr.gmin > rr.gmin) begin
      o.gmin = rr.gmin;
      o.cnt  = rr.cnt;
      o.gsec = smin(lr.gmin, rr.gsec);
      o.tvam = rr.tvam;
    end else if (lr.gmin < rr.gmin) begin
      o.gmin = lr.gmin;
      o.cnt  = lr.cnt;
      o.gsec = smin(lr.gsec, rr.gmin);
      o.tvam = lr.tvam;
    end else begin
      o.gmin = lr.gmin;
      o.cnt  = lr.cnt + rr.cnt;
      o.gsec = smin(lr.gsec, rr.gsec);
      o.tvam = smax(lr.tvam, rr.tvam);
    end
    return o;
  endfunction

  function automatic rec_t leaf_rec(input logic signed [63:0] v, input logic act);
    rec_t o;
    o.pa   = '0;
    o.pp   = '0;
    o.gsum = '0;
    if (act) begin
      o.sum  = v;
      o.mx   = v;
      o.tvam = v;
      o.hm   = v;
      o.gmin = '0;
      o.gsec = BIG;
      o.cnt  = CNT_W'(1);
    end else begin
      o.sum  = '0;
      o.mx   = '0;
      o.tvam = '0;
      o.hm   = '0;
      o.gmin = BIG;
      o.gsec = BIG;
      o.cnt  = '0;
    end
    return o;
  endfunction

  function automatic frame_t make_frame(input logic [1:0] kind, input logic [NODE_W-1:0] k,
                                        input logic [POS_W-1:0] l, input logic [DEP_W-1:0] d,
                                        input logic [1:0] ph);
    frame_t f;
    f.kind = kind;
    f.k    = k;
    f.l    = l;
    f.d    = d;
    f.ph   = ph;
    return f;
  endfunction

  // node memory
  rec_t mem [NODES];
  rec_t rd_q;
  logic              rd_en, wr_en;
  logic [NODE_W-1:0] rd_addr, wr_addr;
  rec_t              wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // frame stack
  frame_t            stk_q [STK_D];
  logic [SP_W-1:0]   sp_q;
  logic [SPI_W-1:0]  spm1;
  frame_t            top, top_new, push_fr;
  logic              top_we, push_en, pop_en;

  assign spm1 = (sp_q == '0) ? '0 : SPI_W'(sp_q - SP_W'(1));
  assign top  = stk_q[spm1];

  always_ff @(posedge clk_i) begin
    if (top_we) begin
      stk_q[spm1] <= top_new;
    end
    if (push_en) begin
      stk_q[SPI_W'(sp_q)] <= push_fr;
    end
  end

  // registers
  logic [4:0]          state_q, state_d;
  logic [10:0]         act_q;
  logic                rb_q, rb_d, init_q, init_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         out_q, out_d;
  logic [2:0]          func_q, func_d;
  logic [POS_W-1:0]    a_q, a_d, b_q, b_d;
  logic signed [63:0]  x_q, x_d, acc_q, acc_d, tgt_q, tgt_d;
  rec_t                rec_p_q, rec_p_d, rec_c_q, rec_c_d;
  logic [31+CNT_W:0]   pl_q, pl_d;
  logic [31:0]         ph_q, ph_d;
  logic                flag_q, flag_d, csel_q, csel_d;
  logic [LEAF_W-1:0]   cnt_q, cnt_d;

  // input fields
  logic [2:0]         in_func;
  logic [10:0]        in_start, in_end;
  logic signed [63:0] in_value;
  logic [POS_W-1:0]   ne, in_a, in_b;

  assign in_func  = s_axis_tdata[2:0];
  assign in_start = s_axis_tdata[13:3];
  assign in_end   = s_axis_tdata[24:14];
  assign in_value = s_axis_tdata[88:25];

  assign ne   = (32'(act_q) < 32'(ELEMENTS)) ? POS_W'(act_q) : POS_W'(ELEMENTS);
  assign in_a = (32'(in_start) > 32'(ne)) ? ne : POS_W'(in_start);
  assign in_b = (32'(in_end) > 32'(ne)) ? ne : POS_W'(in_end);

  // current node geometry
  logic [DEP_W-1:0]  t_sh;
  logic [POS_W-1:0]  t_size, t_r, r_l;
  logic              t_leaf, t_disj, t_cov;
  logic [NODE_W-1:0] pu_k, pu_lk, pu_rk, leaf_addr;

  assign t_sh   = DEP_W'(LOG_L) - top.d;
  assign t_size = POS_W'(1) << t_sh;
  assign t_r    = top.l + t_size;
  assign r_l    = top.l + (t_size >> 1);
  assign t_leaf = (top.d == DEP_W'(LOG_L));
  assign t_disj = (b_q <= top.l) || (t_r <= a_q);
  assign t_cov  = (a_q <= top.l) && (t_r <= b_q);

  assign pu_k      = rb_q ? NODE_W'(cnt_q) : top.k;
  assign pu_lk     = {pu_k[NODE_W-2:0], 1'b1};
  assign pu_rk     = pu_lk + NODE_W'(1);
  assign leaf_addr = NODE_W'(LEAVES - 1) + NODE_W'(cnt_q);

  // gap-minimum update: product in two 32-bit halves
  logic signed [63:0] diff, prod, qv;
  rec_t               set_rec;
  logic               is_max, pend;

  assign diff = tgt_q - rec_c_q.gmin;
  assign prod = 64'(pl_q) + {ph_q, 32'b0};
  always_comb begin
    set_rec      = rec_c_q;
    set_rec.gsum = rec_c_q.gsum + prod;
    set_rec.gmin = tgt_q;
  end

  assign is_max = (func_q == FUNC_MAX) || (func_q == FUNC_HMAX);
  assign pend   = (rec_p_q.pa != '0) || (rec_p_q.pp != '0);

  always_comb begin
    unique case (func_q)
      FUNC_MAX:  qv = rd_q.mx;
      FUNC_SUM:  qv = rd_q.sum;
      FUNC_HMAX: qv = rd_q.hm;
      default:   qv = rd_q.sum + rd_q.gsum;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rb_d        = rb_q;
    init_d      = init_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_d       = out_q;
    func_d      = func_q;
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    acc_d       = acc_q;
    tgt_d       = tgt_q;
    rec_p_d     = rec_p_q;
    rec_c_d     = rec_c_q;
    pl_d        = pl_q;
    ph_d        = ph_q;
    flag_d      = flag_q;
    csel_d      = csel_q;
    cnt_d       = cnt_q;
    rd_en       = 1'b0;
    rd_addr     = top.k;
    wr_en       = 1'b0;
    wr_addr     = top.k;
    wr_data     = rec_p_q;
    top_we      = 1'b0;
    top_new     = top;
    push_en     = 1'b0;
    push_fr     = make_frame(top.kind, pu_lk, top.l, DEP_W'(top.d + 1'b1), P_ENTER);
    pop_en      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d = in_func;
          a_d    = in_a;
          b_d    = in_b;
          x_d    = in_value;
          unique case (in_func)
            FUNC_ADD: begin
              if (in_a < in_b) begin
                push_en = 1'b1;
                push_fr = make_frame(K_AR, '0, '0, '0, P_ENTER);
                state_d = S_FRAME;
              end
            end
            FUNC_MAX, FUNC_HMAX: begin
              acc_d   = -BIG;
              push_en = 1'b1;
              push_fr = make_frame(K_QR, '0, '0, '0, P_ENTER);
              state_d = S_FRAME;
            end
            FUNC_SUM, FUNC_HSUM: begin
              acc_d   = '0;
              push_en = 1'b1;
              push_fr = make_frame(K_QR, '0, '0, '0, P_ENTER);
              state_d = S_FRAME;
            end
            FUNC_LOAD: begin
              if (32'(in_start) < 32'(ne)) begin
                state_d = S_LOAD;
              end
            end
            FUNC_BUILD: begin
              cnt_d   = '0;
              rb_d    = 1'b1;
              state_d = S_RB_LRD;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = NODE_W'(LEAVES - 1) + NODE_W'(a_q);
        wr_data = leaf_rec(x_q, 1'b1);
        state_d = S_IDLE;
      end
      S_FRAME: begin
        if (sp_q == '0) begin
          state_d = (func_q == FUNC_ADD) ? S_IDLE : S_OUT;
        end else begin
          unique case (top.ph)
            P_ENTER: begin
              unique case (top.kind)
                K_RG: begin
                  rd_en   = 1'b1;
                  state_d = S_RG_RD;
                end
                default: begin
                  if (t_disj) begin
                    pop_en = 1'b1;
                  end else begin
                    rd_en = 1'b1;
                    if (!t_cov) begin
                      state_d = S_PD1;
                    end else if (top.kind == K_AR) begin
                      state_d = S_AR_RD;
                    end else begin
                      state_d = S_QR_RD;
                    end
                  end
                end
              endcase
            end
            P_RIGHT: begin
              top_we     = 1'b1;
              top_new.ph = P_PULL;
              push_en    = 1'b1;
              push_fr    = make_frame(top.kind, pu_rk, r_l, DEP_W'(top.d + 1'b1), P_ENTER);
            end
            default: begin
              if (top.kind == K_QR) begin
                pop_en = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = pu_lk;
                state_d = S_PU_A;
              end
            end
          endcase
        end
      end
      S_AR_RD: begin
        rec_p_d = apply_add(rd_q, x_q, x_q, t_sh);
        state_d = S_AR_WR;
      end
      S_AR_WR: begin
        wr_en        = 1'b1;
        top_we       = 1'b1;
        top_new.kind = K_RG;
        top_new.ph   = P_ENTER;
        state_d      = S_FRAME;
      end
      S_RG_RD: begin
        if (rd_q.gmin >= 0) begin
          pop_en  = 1'b1;
          state_d = S_FRAME;
        end else if (rd_q.gsec > 0 || t_leaf) begin
          rec_c_d = rd_q;
          tgt_d   = '0;
          state_d = S_RG_MUL;
        end else begin
          state_d = S_PD1;
        end
      end
      S_RG_MUL: begin
        pl_d    = diff[31:0] * rec_c_q.cnt;
        ph_d    = 32'(diff[63:32] * rec_c_q.cnt);
        state_d = S_RG_WR;
      end
      S_RG_WR: begin
        wr_en   = 1'b1;
        wr_data = set_rec;
        pop_en  = 1'b1;
        state_d = S_FRAME;
      end
      S_QR_RD: begin
        acc_d   = is_max ? smax(acc_q, qv) : acc_q + qv;
        pop_en  = 1'b1;
        state_d = S_FRAME;
      end
      // push pending add and gap minimum of the node into both children
      S_PD1: begin
        rec_p_d = rd_q;
        tgt_d   = rd_q.gmin;
        csel_d  = 1'b0;
        rd_en   = 1'b1;
        rd_addr = pu_lk;
        state_d = S_PD2;
      end
      S_PD2: begin
        rec_c_d = pend ? apply_add(rd_q, rec_p_q.pa, rec_p_q.pp, t_sh - DEP_W'(1)) : rd_q;
        state_d = S_PD3;
      end
      S_PD3: begin
        pl_d    = diff[31:0] * rec_c_q.cnt;
        ph_d    = 32'(diff[63:32] * rec_c_q.cnt);
        flag_d  = rec_c_q.gmin < tgt_q;
        state_d = S_PD4;
      end
      S_PD4: begin
        wr_en   = 1'b1;
        wr_addr = csel_q ? pu_rk : pu_lk;
        wr_data = flag_q ? set_rec : rec_c_q;
        if (!csel_q) begin
          csel_d  = 1'b1;
          rd_en   = 1'b1;
          rd_addr = pu_rk;
          state_d = S_PD2;
        end else begin
          state_d = S_PD5;
        end
      end
      S_PD5: begin
        wr_en      = 1'b1;
        wr_data.pa = '0;
        wr_data.pp = '0;
        top_we     = 1'b1;
        top_new.ph = P_RIGHT;
        push_en    = 1'b1;
        state_d    = S_FRAME;
      end
      S_PU_A: begin
        rec_c_d = rd_q;
        rd_en   = 1'b1;
        rd_addr = pu_rk;
        state_d = S_PU_B;
      end
      S_PU_B: begin
        wr_en   = 1'b1;
        wr_addr = pu_k;
        wr_data = pull_up(rec_c_q, rd_q);
        if (rb_q) begin
          if (cnt_q == '0) begin
            rb_d    = 1'b0;
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q - LEAF_W'(1);
            state_d = S_RB_IRD;
          end
        end else begin
          pop_en  = 1'b1;
          state_d = S_FRAME;
        end
      end
      S_RB_LRD: begin
        rd_en   = 1'b1;
        rd_addr = leaf_addr;
        state_d = S_RB_LWR;
      end
      S_RB_LWR: begin
        wr_en   = 1'b1;
        wr_addr = leaf_addr;
        wr_data = leaf_rec(init_q ? 64'sd0 : rd_q.mx, 32'(cnt_q) < 32'(ne));
        if (cnt_q == LEAF_W'(LEAVES - 1)) begin
          cnt_d   = LEAF_W'(LEAVES - 2);
          state_d = S_RB_IRD;
        end else begin
          cnt_d   = cnt_q + LEAF_W'(1);
          state_d = S_RB_LRD;
        end
      end
      S_RB_IRD: begin
        rd_en   = 1'b1;
        rd_addr = pu_lk;
        state_d = S_PU_A;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RB_LRD;
      sp_q        <= '0;
      rb_q        <= 1'b1;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      act_q       <= ACTIVE_LENGTH_RST;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_q + SP_W'(push_en) - SP_W'(pop_en);
      rb_q        <= rb_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && paddr == ADDR_ACTIVE_LENGTH) begin
        act_q <= pwdata[10:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    func_q  <= func_d;
    a_q     <= a_d;
    b_q     <= b_d;
    x_q     <= x_d;
    acc_q   <= acc_d;
    tgt_q   <= tgt_d;
    rec_p_q <= rec_p_d;
    rec_c_q <= rec_c_d;
    pl_q    <= pl_d;
    ph_q    <= ph_d;
    flag_q  <= flag_d;
    csel_q  <= csel_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr == ADDR_ACTIVE_LENGTH) ? 32'(act_q) : '0;

endmodule
